[sv/lr_pkg.sv]
// Shared types and constants for the line rasterizer.
`default_nettype none
package lr_pkg;

  localparam int CoordW = 6;
  localparam int ColorW = 24;
  localparam int StepW  = CoordW + 1;
  localparam int ErrW   = 10;

  // Line classes
  localparam logic [2:0] MODE_HORZ     = 3'd0;
  localparam logic [2:0] MODE_VERT     = 3'd1;
  localparam logic [2:0] MODE_SHAL_UP  = 3'd2;
  localparam logic [2:0] MODE_STEEP_UP = 3'd3;
  localparam logic [2:0] MODE_SHAL_DN  = 3'd4;
  localparam logic [2:0] MODE_STEEP_DN = 3'd5;

  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    logic [ColorW-1:0] line_color;
  } req_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [ColorW-1:0] pixel_color;
    logic              last_pixel;
  } pix_t;

  // Prepared line: start point, pixels left after the first, error set-up
  typedef struct packed {
    logic [CoordW-1:0]        x0;
    logic [CoordW-1:0]        y0;
    logic [CoordW-1:0]        remain;
    logic [2:0]               mode;
    logic [StepW-1:0]         step_a;
    logic [StepW-1:0]         step_b;
    logic signed [ErrW-1:0]   err;
    logic [ColorW-1:0]        color;
  } cmd_t;

endpackage
`default_nettype wire

[sv/lr_front.sv]
// Front end: clamps and orders the endpoints and classifies the line.
`default_nettype none
module lr_front #(
  parameter int COORD_RANGE = 64
) (
  input  var lr_pkg::req_t req,
  output lr_pkg::cmd_t     cmd
);

  localparam logic [lr_pkg::CoordW:0]   Limit = (lr_pkg::CoordW + 1)'(COORD_RANGE);
  localparam logic [lr_pkg::CoordW-1:0] Top   = lr_pkg::CoordW'(COORD_RANGE - 1);

  logic [lr_pkg::CoordW-1:0] ax, ay, bx, by;
  logic [lr_pkg::CoordW-1:0] x0, y0, x1, y1;
  logic [lr_pkg::CoordW-1:0] dx, ady;
  logic                      rising;

  function automatic logic [lr_pkg::CoordW-1:0] clamp(input logic [lr_pkg::CoordW-1:0] v);
    clamp = ({1'b0, v} >= Limit) ? Top : v;
  endfunction

  // Saturate coordinates and order endpoints so x does not decrease
  always_comb begin
    ax = clamp(req.start_x);
    ay = clamp(req.start_y);
    bx = clamp(req.end_x);
    by = clamp(req.end_y);
    if (ax > bx) begin
      x0 = bx; y0 = by; x1 = ax; y1 = ay;
    end else begin
      x0 = ax; y0 = ay; x1 = bx; y1 = by;
    end
    dx     = x1 - x0;
    rising = (y1 >= y0);
    ady    = rising ? (y1 - y0) : (y0 - y1);
  end

  // Classify and set up the error term
  always_comb begin
    cmd.x0     = x0;
    cmd.y0     = y0;
    cmd.color  = req.line_color;
    cmd.step_a = '0;
    cmd.step_b = '0;
    cmd.err    = '0;
    if (y0 == y1) begin
      cmd.mode   = lr_pkg::MODE_HORZ;
      cmd.remain = dx;
    end else if (x0 == x1) begin
      cmd.mode   = lr_pkg::MODE_VERT;
      cmd.y0     = rising ? y0 : y1;
      cmd.remain = ady;
    end else if (ady > dx) begin
      cmd.mode   = rising ? lr_pkg::MODE_STEEP_UP : lr_pkg::MODE_STEEP_DN;
      cmd.step_a = {dx, 1'b0};
      cmd.step_b = {ady, 1'b0};
      cmd.err    = $signed({3'b000, dx, 1'b0}) - $signed({4'b0000, ady});
      cmd.remain = ady;
    end else begin
      cmd.mode   = rising ? lr_pkg::MODE_SHAL_UP : lr_pkg::MODE_SHAL_DN;
      cmd.step_a = {ady, 1'b0};
      cmd.step_b = {dx, 1'b0};
      cmd.err    = $signed({3'b000, ady, 1'b0}) - $signed({4'b0000, dx});
      cmd.remain = dx;
    end
  end

endmodule
`default_nettype wire

[sv/lr_cmd_fifo.sv]
// Short queue of prepared lines between the front end and the stepper.
`default_nettype none
module lr_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  var logic         clk,
  input  var logic         rst,
  input  var logic         wr_en,
  input  var lr_pkg::cmd_t wr_data,
  output logic             full,
  input  var logic         rd_en,
  output lr_pkg::cmd_t     rd_data,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  lr_pkg::cmd_t    entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  // Store items
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/lr_back.sv]
// Back end: steps the midpoint error term and emits one pixel per cycle while the output has room.
`default_nettype none
module lr_back (
  input  var logic         clk,
  input  var logic         rst,
  input  var logic         cmd_empty,
  input  var lr_pkg::cmd_t cmd,
  output logic             cmd_take,
  input  var logic         pop,
  output logic             empty,
  output lr_pkg::pix_t     pix
);

  logic                           busy;
  logic [lr_pkg::CoordW-1:0]      cur_x, cur_y, remain;
  logic [lr_pkg::CoordW-1:0]      x_next, y_next;
  logic [2:0]                     mode;
  logic [lr_pkg::StepW-1:0]       step_a, step_b;
  logic signed [lr_pkg::ErrW-1:0] err, err_next, a_ext, b_ext;
  logic [lr_pkg::ColorW-1:0]      color;
  logic                           out_valid;
  logic                           out_free;
  logic                           err_pos;

  assign out_free = !out_valid || pop;
  assign cmd_take = !busy && !cmd_empty;
  assign empty    = !out_valid;
  assign a_ext    = $signed({3'b000, step_a});
  assign b_ext    = $signed({3'b000, step_b});
  assign err_pos  = !err[lr_pkg::ErrW-1] && (err != '0);

  // Work out the next pixel of the line
  always_comb begin
    x_next   = cur_x;
    y_next   = cur_y;
    err_next = err;
    unique case (mode) inside
      lr_pkg::MODE_HORZ: x_next = cur_x + 1'b1;
      lr_pkg::MODE_VERT: y_next = cur_y + 1'b1;
      lr_pkg::MODE_SHAL_UP, lr_pkg::MODE_SHAL_DN: begin
        x_next = cur_x + 1'b1;
        if (err_pos) begin
          y_next   = (mode == lr_pkg::MODE_SHAL_UP) ? cur_y + 1'b1 : cur_y - 1'b1;
          err_next = err - b_ext + a_ext;
        end else begin
          err_next = err + a_ext;
        end
      end
      lr_pkg::MODE_STEEP_UP, lr_pkg::MODE_STEEP_DN: begin
        y_next = (mode == lr_pkg::MODE_STEEP_UP) ? cur_y + 1'b1 : cur_y - 1'b1;
        if (err_pos) begin
          x_next   = cur_x + 1'b1;
          err_next = err - b_ext + a_ext;
        end else begin
          err_next = err + a_ext;
        end
      end
      default: begin
        x_next   = cur_x;
        y_next   = cur_y;
        err_next = err;
      end
    endcase
  end

  // Line state: load a prepared line, then step while the output has room
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd_take) begin
      busy <= 1'b1;
    end else if (busy && out_free && (remain == '0)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur_x  <= cmd.x0;
      cur_y  <= cmd.y0;
      remain <= cmd.remain;
      mode   <= cmd.mode;
      step_a <= cmd.step_a;
      step_b <= cmd.step_b;
      err    <= cmd.err;
      color  <= cmd.color;
    end else if (busy && out_free) begin
      cur_x  <= x_next;
      cur_y  <= y_next;
      err    <= err_next;
      remain <= remain - 1'b1;
    end
  end

  // Output register: hold the item until it is popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (busy && out_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && out_free) begin
      pix.pixel_x     <= cur_x;
      pix.pixel_y     <= cur_y;
      pix.pixel_color <= color;
      pix.last_pixel  <= (remain == '0);
    end
  end

endmodule
`default_nettype wire

[sv/line_rasterizer.sv]
// Line rasterizer: one request in, every pixel of the line out, one pixel per cycle while the result side pops.
// A request passes the queue, the stepper's line registers and the output register in that order.
// A line of n pixels (1 to 64) occupies the stepper for one load step and one step per pixel,
//   the stepper making a single error update per pixel.
// A two-entry queue of prepared lines lets requests be taken while a line is drawn.
// Reset (synchronous, rst high) empties the queue and the output and idles the stepper.
`default_nettype none
module line_rasterizer #(
  parameter int COORD_RANGE = 64
) (
  input  var logic         clk,
  input  var logic         rst,
  input  var logic         push,
  output logic             full,
  input  var lr_pkg::req_t req,
  output logic             empty,
  input  var logic         pop,
  output lr_pkg::pix_t     pix
);

  lr_pkg::cmd_t front_cmd;
  lr_pkg::cmd_t queue_cmd;
  logic         queue_empty;
  logic         cmd_take;
  logic         accept;

  assign accept = push && !full;

  lr_front #(
    .COORD_RANGE(COORD_RANGE)
  ) u_front (
    .req(req),
    .cmd(front_cmd)
  );

  lr_cmd_fifo #(
    .DEPTH(2)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (accept),
    .wr_data(front_cmd),
    .full   (full),
    .rd_en  (cmd_take),
    .rd_data(queue_cmd),
    .empty  (queue_empty)
  );

  lr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(queue_empty),
    .cmd      (queue_cmd),
    .cmd_take (cmd_take),
    .pop      (pop),
    .empty    (empty),
    .pix      (pix)
  );

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the line rasterizer: directed, random and handshake stress.
module tb_top;

  localparam int CoordW      = lr_pkg::CoordW;
  localparam int ColorW      = lr_pkg::ColorW;
  localparam int RandomItems = 450;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 20;

  // Directed stimulus row: request plus an optional typed-in single pixel
  typedef struct packed {
    lr_pkg::req_t rq;
    logic         typed;
    lr_pkg::pix_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  lr_pkg::req_t line_req = '0;
  logic full;
  logic empty;
  lr_pkg::pix_t pixel;

  lr_pkg::pix_t pending_pixels[$];
  row_t rows[$];
  int   mismatches = 0;
  int   lines_drawn = 0;
  int   pixels_checked = 0;
  int   class_count[0:5];
  bit   hold_req = 1'b0;
  bit   draining = 1'b0;
  int   hold_left = 0;
  int   seg_left = 0;
  int   pop_pct = 100;
  lr_pkg::pix_t want;

  line_rasterizer dut (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .req  (line_req),
    .empty(empty),
    .pop  (pop),
    .pix  (pixel)
  );

  always #5 clk = ~clk;

  // Walk the line the way the block should and queue every pixel it must emit
  function automatic void plot_line(input lr_pkg::req_t r);
    int x0, y0, x1, y1, t, dx, ady, n, err, inc_a, inc_b, i;
    bit up;
    logic [2:0] line_class;
    lr_pkg::pix_t p;
    // coordinates are 6 bits wide, so saturation at the range limit never bites
    x0 = int'(r.start_x);
    y0 = int'(r.start_y);
    x1 = int'(r.end_x);
    y1 = int'(r.end_y);
    err = 0;
    inc_a = 0;
    inc_b = 0;
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dx = x1 - x0;
    up = (y1 >= y0);
    ady = up ? (y1 - y0) : (y0 - y1);
    if (y0 == y1) begin
      line_class = lr_pkg::MODE_HORZ;
      n = dx + 1;
    end else if (x0 == x1) begin
      // vertical lines always run from the smaller y
      line_class = lr_pkg::MODE_VERT;
      if (y0 > y1) begin
        y0 = y1;
      end
      n = ady + 1;
    end else if (ady > dx) begin
      line_class = up ? lr_pkg::MODE_STEEP_UP : lr_pkg::MODE_STEEP_DN;
      inc_a = 2 * dx;
      inc_b = 2 * ady;
      n = ady + 1;
      err = 2 * dx - ady;
    end else begin
      // a tie between spans counts as shallow
      line_class = up ? lr_pkg::MODE_SHAL_UP : lr_pkg::MODE_SHAL_DN;
      inc_a = 2 * ady;
      inc_b = 2 * dx;
      n = dx + 1;
      err = 2 * ady - dx;
    end
    class_count[line_class]++;
    for (i = 0; i < n; i++) begin
      p.pixel_x = x0[CoordW-1:0];
      p.pixel_y = y0[CoordW-1:0];
      p.pixel_color = r.line_color;
      p.last_pixel = (i == n - 1);
      pending_pixels.push_back(p);
      case (line_class)
        lr_pkg::MODE_HORZ: x0++;
        lr_pkg::MODE_VERT: y0++;
        lr_pkg::MODE_SHAL_UP, lr_pkg::MODE_SHAL_DN: begin
          if (err > 0) begin
            y0 = up ? y0 + 1 : y0 - 1;
            err -= inc_b;
          end
          x0++;
          err += inc_a;
        end
        default: begin
          if (err > 0) begin
            x0++;
            err -= inc_b;
          end
          y0 = up ? y0 + 1 : y0 - 1;
          err += inc_a;
        end
      endcase
    end
  endfunction

  // Move a coordinate by up to seven either way, saturated to the grid
  function automatic int nudge(input int base);
    int v;
    v = base + $urandom_range(0, 14) - 7;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return v;
  endfunction

  // Random request: mostly short lines, some full-range, axis-aligned and single points
  function automatic lr_pkg::req_t random_line();
    lr_pkg::req_t r;
    int kind;
    kind = $urandom_range(0, 9);
    r.start_x = CoordW'($urandom_range(0, 63));
    r.start_y = CoordW'($urandom_range(0, 63));
    r.line_color = ColorW'($urandom);
    case (kind)
      0, 1, 2: begin
        r.end_x = CoordW'($urandom_range(0, 63));
        r.end_y = CoordW'($urandom_range(0, 63));
      end
      3, 4, 5, 6: begin
        r.end_x = CoordW'(nudge(int'(r.start_x)));
        r.end_y = CoordW'(nudge(int'(r.start_y)));
      end
      7: begin
        r.end_x = CoordW'($urandom_range(0, 63));
        r.end_y = r.start_y;
      end
      8: begin
        r.end_x = r.start_x;
        r.end_y = CoordW'($urandom_range(0, 63));
      end
      default: begin
        r.end_x = r.start_x;
        r.end_y = r.start_y;
      end
    endcase
    return r;
  endfunction

  function automatic void add_line(input int sx, input int sy, input int ex, input int ey,
                                   input logic [ColorW-1:0] col);
    row_t w;
    w = '0;
    w.rq.start_x = CoordW'(sx);
    w.rq.start_y = CoordW'(sy);
    w.rq.end_x = CoordW'(ex);
    w.rq.end_y = CoordW'(ey);
    w.rq.line_color = col;
    rows.push_back(w);
  endfunction

  // Single point: exactly one pixel, marked last
  function automatic void add_point(input int x, input int y, input logic [ColorW-1:0] col);
    row_t w;
    w.rq.start_x = CoordW'(x);
    w.rq.start_y = CoordW'(y);
    w.rq.end_x = CoordW'(x);
    w.rq.end_y = CoordW'(y);
    w.rq.line_color = col;
    w.typed = 1'b1;
    w.want.pixel_x = CoordW'(x);
    w.want.pixel_y = CoordW'(y);
    w.want.pixel_color = col;
    w.want.last_pixel = 1'b1;
    rows.push_back(w);
  endfunction

  // Offer one item and hold it until taken; push stays high for the caller to keep or drop
  task automatic offer(input lr_pkg::req_t r, input logic typed, input lr_pkg::pix_t exp_pix);
    push <= 1'b1;
    line_req <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    if (typed) begin
      pending_pixels.push_back(exp_pix);
    end else begin
      plot_line(r);
    end
    lines_drawn++;
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // Result side: check each taken pixel, then pick the next pop
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected pixel x=%0d y=%0d", pixel.pixel_x, pixel.pixel_y);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          pixels_checked++;
          if (pixel.pixel_x !== want.pixel_x) begin
            $error("pixel_x: expected %0d, got %0d", want.pixel_x, pixel.pixel_x);
            mismatches++;
          end
          if (pixel.pixel_y !== want.pixel_y) begin
            $error("pixel_y: expected %0d, got %0d", want.pixel_y, pixel.pixel_y);
            mismatches++;
          end
          if (pixel.pixel_color !== want.pixel_color) begin
            $error("pixel_color: expected %06h, got %06h", want.pixel_color, pixel.pixel_color);
            mismatches++;
          end
          if (pixel.last_pixel !== want.last_pixel) begin
            $error("last_pixel: expected %0b, got %0b", want.last_pixel, pixel.last_pixel);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left <= HoldCycles;
        pop <= 1'b0;
      end else if (draining) begin
        pop <= 1'b1;
      end else begin
        // stall in segments, each with its own pop rate
        if (seg_left == 0) begin
          seg_left <= $urandom_range(1, 40);
          case ($urandom_range(0, 3))
            0: pop_pct <= 100;
            1: pop_pct <= 60;
            2: pop_pct <= 25;
            default: pop_pct <= 5;
          endcase
        end else begin
          seg_left <= seg_left - 1;
        end
        pop <= ($urandom_range(1, 100) <= pop_pct);
      end
    end
  end

  // Stimulus
  initial begin
    int sent;
    int k;
    int burst;
    int gap;
    foreach (class_count[k]) class_count[k] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: points at the corners, full-range lines of every class, short edge cases
    add_point(0, 0, 24'h000000);
    add_point(63, 63, 24'hFFFFFF);
    add_point(0, 63, 24'h555555);
    add_point(63, 0, 24'hAAAAAA);
    add_line(0, 0, 63, 0, 24'hFF0000);
    add_line(63, 63, 0, 63, 24'h00FF00);
    add_line(5, 0, 5, 63, 24'h0000FF);
    add_line(40, 63, 40, 0, 24'h123456);
    add_line(0, 0, 63, 63, 24'hFFFFFF);
    add_line(63, 0, 0, 63, 24'h000000);
    add_line(0, 0, 63, 1, 24'hABCDEF);
    add_line(0, 62, 63, 20, 24'h654321);
    add_line(0, 0, 1, 63, 24'h0F0F0F);
    add_line(63, 0, 62, 63, 24'hF0F0F0);
    add_line(10, 10, 14, 30, 24'h808080);
    add_line(3, 7, 4, 5, 24'h7F7F7F);
    add_line(0, 5, 5, 0, 24'h010203);
    add_line(20, 20, 21, 21, 24'hFEDCBA);
    add_line(30, 30, 31, 30, 24'h00FFFF);
    add_line(33, 12, 33, 11, 24'hFF00FF);
    foreach (rows[k]) begin
      offer(rows[k].rq, rows[k].typed, rows[k].want);
      if ($urandom_range(0, 2) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    push <= 1'b0;
    wait_drained();

    // long receiver hold while items keep coming, so the input side backs up
    sent = 0;
    hold_req = 1'b1;
    for (k = 0; k < 12; k++) begin
      offer(random_line(), 1'b0, '0);
      sent++;
    end
    push <= 1'b0;
    wait_drained();

    // random part in bursts with gaps; pause once midway until all pixels are out
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 16);
      for (k = 0; k < burst && sent < RandomItems; k++) begin
        offer(random_line(), 1'b0, '0);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (sent >= RandomItems / 2 && sent - burst < RandomItems / 2) begin
        push <= 1'b0;
        wait_drained();
      end else if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push <= 1'b0;

    // drain with the receiver always ready, then watch for stray pixels
    draining = 1'b1;
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("tb_top: %0d lines sent, %0d pixels checked", lines_drawn, pixels_checked);
    $display("tb_top: horiz %0d, vert %0d, shallow up/down %0d/%0d, steep up/down %0d/%0d",
             class_count[lr_pkg::MODE_HORZ], class_count[lr_pkg::MODE_VERT],
             class_count[lr_pkg::MODE_SHAL_UP], class_count[lr_pkg::MODE_SHAL_DN],
             class_count[lr_pkg::MODE_STEEP_UP], class_count[lr_pkg::MODE_STEEP_DN]);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
